// ===== design/tprav_pkg.sv =====
// Package for the tachometer period-to-rate averager.
// Holds the shared widths, constants, queue item type and back-end state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tprav_pkg;

   localparam int CAPTURE_W = 16;
   localparam int RATE_W    = 24;
   localparam int TICK_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [RATE_W-1:0] RATE_MAX        = 24'hFF_FFFF;
   localparam logic [TICK_W-1:0] TICK_RATE_RESET = 32'd10_000_000;

   // Register index, taken from paddr above the byte offset
   localparam logic CSR_INDEX_TICK_RATE = 1'b0;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [CAPTURE_W-1:0] period;
      logic                 zero_period;
   } front_item_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_WRITE
   } back_state_type;

endpackage : tprav_pkg

`default_nettype wire

// ===== design/tach_period_to_rate_averager_core.sv =====
// Tachometer period-to-rate averager, top level.
// Each capture passes through the queue, the 32-step divider (skipped for a zero period)
// and the write state into the output register. The back end divides one item at a time
// while a two-entry queue takes further captures. Reset (synchronous, active high):
// tick_rate_q8 = 10000000, capture, history and sum zeroed, queue and output emptied.
`timescale 1ns / 1ps
`default_nettype none

module tach_period_to_rate_averager_core #(
   parameter int HISTORY_DEPTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   output logic                                  full,
   input  wire logic [tprav_pkg::CAPTURE_W-1:0]  req_capture_time,
   output logic                                  empty,
   input  wire logic                             pop,
   output logic [tprav_pkg::RATE_W-1:0]          rsp_rate_q8,
   output logic [tprav_pkg::RATE_W-1:0]          rsp_average_rate_q8,
   output logic                                  rsp_zero_period,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [tprav_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [tprav_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tprav_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                  pready
);
   import tprav_pkg::*;

   logic              tick_sel;
   logic              csr_write;
   logic [TICK_W-1:0] tick_rate_ff;
   logic [TICK_W-1:0] tick_rate_in;
   logic              queue_write;
   logic              queue_read;
   logic              queue_full;
   logic              queue_empty;
   front_item_type    front_item;
   front_item_type    back_item;

   // Configuration register, decoded by word index
   assign pready    = 1'b1;
   assign tick_sel  = (paddr[CSR_ADDR_W-1] == CSR_INDEX_TICK_RATE);
   assign csr_write = psel && penable && pwrite && pready;
   assign tick_rate_in = (csr_write && tick_sel) ? pwdata : tick_rate_ff;
   assign prdata    = tick_sel ? tick_rate_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
      end else begin
         tick_rate_ff <= tick_rate_in;
      end
   end

   assign full = queue_full;

   tprav_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .req_capture_time (req_capture_time),
      .queue_full       (queue_full),
      .queue_write      (queue_write),
      .queue_item       (front_item)
   );

   tprav_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .write_en   (queue_write),
      .write_item (front_item),
      .read_en    (queue_read),
      .read_item  (back_item),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   tprav_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .tick_rate_q8        (tick_rate_ff),
      .queue_item          (back_item),
      .queue_empty         (queue_empty),
      .queue_read          (queue_read),
      .pop                 (pop),
      .empty               (empty),
      .rsp_rate_q8         (rsp_rate_q8),
      .rsp_average_rate_q8 (rsp_average_rate_q8),
      .rsp_zero_period     (rsp_zero_period)
   );

endmodule : tach_period_to_rate_averager_core

`default_nettype wire

// ===== design/tprav_front.sv =====
// Front end: accepts capture timestamps, forms the period and flags a zero period.
// Depends on tprav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tprav_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [tprav_pkg::CAPTURE_W-1:0] req_capture_time,
   input  wire logic                           queue_full,
   output logic                                queue_write,
   output tprav_pkg::front_item_type           queue_item
);
   import tprav_pkg::*;

   logic [CAPTURE_W-1:0] last_capture_ff;
   logic [CAPTURE_W-1:0] last_capture_in;
   logic [CAPTURE_W-1:0] period;

   // Take a transfer whenever the queue has room
   assign queue_write = push && !queue_full;

   // Period modulo 2^16 against the previous timestamp
   assign period = req_capture_time - last_capture_ff;

   always_comb begin
      queue_item.period      = period;
      queue_item.zero_period = (period == '0);
   end

   assign last_capture_in = queue_write ? req_capture_time : last_capture_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_capture_ff <= '0;
      end else begin
         last_capture_ff <= last_capture_in;
      end
   end

endmodule : tprav_front

`default_nettype wire

// ===== design/tprav_queue.sv =====
// Short queue that decouples the front end from the back end.
// Depends on tprav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tprav_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      write_en,
   input  wire tprav_pkg::front_item_type write_item,
   input  wire logic                      read_en,
   output tprav_pkg::front_item_type      read_item,
   output logic                           full,
   output logic                           empty
);
   import tprav_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   front_item_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               do_write;
   logic               do_read;

   assign full      = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_write  = write_en && !full;
   assign do_read   = read_en && !empty;
   assign read_item = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload, no reset needed
   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= write_item;
      end
   end

endmodule : tprav_queue

`default_nettype wire

// ===== design/tprav_divider.sv =====
// Restoring divider, 32-bit dividend by 16-bit non-zero divisor, one bit a cycle.
// Depends on tprav_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tprav_divider (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [tprav_pkg::TICK_W-1:0]    dividend,
   input  wire logic [tprav_pkg::CAPTURE_W-1:0] divisor,
   output logic                                 done,
   output logic [tprav_pkg::TICK_W-1:0]         quotient
);
   import tprav_pkg::*;

   localparam int STEP_W = $clog2(TICK_W);

   logic [TICK_W-1:0]    quot_ff;
   logic [TICK_W-1:0]    quot_in;
   logic [CAPTURE_W-1:0] rem_ff;
   logic [CAPTURE_W-1:0] rem_in;
   logic [CAPTURE_W-1:0] divisor_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [CAPTURE_W:0]   trial;
   logic [CAPTURE_W:0]   diff;
   logic                 fits;

   // Shift next dividend bit into the partial remainder and try the subtract
   assign trial = {rem_ff, quot_ff[TICK_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      rem_in  = fits ? diff[CAPTURE_W-1:0] : trial[CAPTURE_W-1:0];
      quot_in = {quot_ff[TICK_W-2:0], fits};
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(TICK_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers, loaded on start and stepped while busy
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

endmodule : tprav_divider

`default_nettype wire

// ===== design/tprav_back.sv =====
// Back end: divides, saturates, updates the rate history and running sum,
// and holds the result in an output register. Depends on tprav_pkg, tprav_divider.
`timescale 1ns / 1ps
`default_nettype none

module tprav_back #(
   parameter int HISTORY_DEPTH = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [tprav_pkg::TICK_W-1:0] tick_rate_q8,
   input  wire tprav_pkg::front_item_type    queue_item,
   input  wire logic                         queue_empty,
   output logic                              queue_read,
   input  wire logic                         pop,
   output logic                              empty,
   output logic [tprav_pkg::RATE_W-1:0]      rsp_rate_q8,
   output logic [tprav_pkg::RATE_W-1:0]      rsp_average_rate_q8,
   output logic                              rsp_zero_period
);
   import tprav_pkg::*;

   localparam int SHIFT_W = $clog2(HISTORY_DEPTH);
   localparam int SUM_W   = RATE_W + SHIFT_W;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [RATE_W-1:0] rate_ff;
   logic [RATE_W-1:0] rate_in;
   logic              zero_ff;
   logic [RATE_W-1:0] hist_ff [HISTORY_DEPTH];
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic              out_valid_ff;
   logic              slot_free;
   logic              div_start;
   logic              div_done;
   logic              commit;
   logic [TICK_W-1:0] div_quotient;

   tprav_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tick_rate_q8),
      .divisor  (queue_item.period),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign slot_free = !out_valid_ff || pop;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!queue_empty) begin
               state_in = queue_item.zero_period ? BACK_WRITE : BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (div_done) begin
               state_in = BACK_WRITE;
            end
         end
         BACK_WRITE: begin
            if (slot_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      queue_read = 1'b0;
      div_start  = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            queue_read = !queue_empty;
            div_start  = !queue_empty && !queue_item.zero_period;
         end
         BACK_DIVIDE: begin
         end
         BACK_WRITE: begin
            commit = slot_free;
         end
         default: begin
         end
      endcase
   end

   // Saturate the quotient, or force the maximum on a zero period
   always_comb begin
      rate_in = rate_ff;
      if (queue_read && queue_item.zero_period) begin
         rate_in = RATE_MAX;
      end else if (state_ff == BACK_DIVIDE && div_done) begin
         rate_in = (div_quotient[TICK_W-1:RATE_W] != '0) ? RATE_MAX
                                                          : div_quotient[RATE_W-1:0];
      end
   end

   // Drop the oldest entry from the sum and add the newest
   assign sum_in = sum_ff - SUM_W'(hist_ff[HISTORY_DEPTH-1]) + SUM_W'(rate_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
         sum_ff       <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (commit) begin
            out_valid_ff <= 1'b1;
            sum_ff       <= sum_in;
            hist_ff[0]   <= rate_ff;
            for (int i = 1; i < HISTORY_DEPTH; i++) begin
               hist_ff[i] <= hist_ff[i-1];
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Working and output payload registers
   always_ff @(posedge clock) begin
      rate_ff <= rate_in;
      if (queue_read) begin
         zero_ff <= queue_item.zero_period;
      end
      if (commit) begin
         rsp_rate_q8         <= rate_ff;
         rsp_average_rate_q8 <= sum_in[SHIFT_W +: RATE_W];
         rsp_zero_period     <= zero_ff;
      end
   end

   assign empty = !out_valid_ff;

endmodule : tprav_back

`default_nettype wire

// ===== verif/tprav_rate_checker.sv =====
// Result checker for the tachometer period-to-rate averager.
// Watches the capture, result and register channels, predicts each result and compares.
// Depends on tprav_pkg.
`timescale 1ns / 1ps

module tprav_rate_checker
   import tprav_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  full,
   input  logic [CAPTURE_W-1:0]  capture_time,
   input  logic                  empty,
   input  logic                  pop,
   input  logic [RATE_W-1:0]     rate_q8,
   input  logic [RATE_W-1:0]     average_rate_q8,
   input  logic                  zero_period,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic [CSR_DATA_W-1:0] prdata,
   input  logic                  pready,
   output int                    mismatches,
   output int                    outstanding,
   output int                    results_checked
);

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic [RATE_W-1:0] average;
      logic              zero;
   } rate_result_type;

   rate_result_type      awaited_rates[$];
   logic [TICK_W-1:0]    tick_rate;
   logic [CAPTURE_W-1:0] prev_capture;
   logic [RATE_W-1:0]    rate_line [HISTORY_DEPTH];
   logic [31:0]          rate_sum;
   int                   fault_count = 0;
   int                   checked_count = 0;

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (fault_count < 10) begin
         $display("mismatch in %s: expected 0x%0h, got 0x%0h at %0t ns",
                  what, want, got, $realtime);
      end
      fault_count++;
   endtask

   always @(posedge clock) begin : watch
      rate_result_type      head;
      rate_result_type      fresh;
      logic [CAPTURE_W-1:0] period;
      logic [TICK_W-1:0]    quotient;
      if (reset) begin
         tick_rate    = TICK_RATE_RESET;
         prev_capture = '0;
         rate_sum     = '0;
         foreach (rate_line[i]) rate_line[i] = '0;
         awaited_rates.delete();
      end else begin
         // compare a result transfer with the oldest prediction
         if (pop && !empty) begin
            if (awaited_rates.size() == 0) begin
               note_mismatch("unexpected result (rate)", 0, rate_q8);
            end else begin
               head = awaited_rates.pop_front();
               checked_count++;
               if (rate_q8 !== head.rate)
                  note_mismatch("rate_q8", head.rate, rate_q8);
               if (average_rate_q8 !== head.average)
                  note_mismatch("average_rate_q8", head.average, average_rate_q8);
               if (zero_period !== head.zero)
                  note_mismatch("zero_period", head.zero, zero_period);
            end
         end
         // predict the result of a capture transfer
         if (push && !full) begin
            period       = capture_time - prev_capture;
            prev_capture = capture_time;
            if (period == '0) begin
               fresh.rate = RATE_MAX;
               fresh.zero = 1'b1;
            end else begin
               quotient   = tick_rate / {16'd0, period};
               fresh.rate = (quotient > RATE_MAX) ? RATE_MAX : quotient[RATE_W-1:0];
               fresh.zero = 1'b0;
            end
            // drop the oldest rate, shift the history and add the newest
            rate_sum = rate_sum - rate_line[HISTORY_DEPTH-1] + fresh.rate;
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) rate_line[i] = rate_line[i-1];
            rate_line[0]  = fresh.rate;
            fresh.average = RATE_W'(rate_sum / HISTORY_DEPTH);
            awaited_rates.push_back(fresh);
         end
         // register access phase; the index sits just above the byte offset
         if (psel && penable && pready && paddr[2] == CSR_INDEX_TICK_RATE) begin
            if (pwrite)
               tick_rate = pwdata;
            else if (prdata !== tick_rate)
               note_mismatch("tick_rate_q8 read", tick_rate, prdata);
         end
      end
      mismatches      <= fault_count;
      outstanding     <= awaited_rates.size();
      results_checked <= checked_count;
   end

endmodule

// ===== verif/tach_period_to_rate_averager_core_tb.sv =====
// Testbench top for tach_period_to_rate_averager_core.
// Drives captures, result pops and register accesses; the checking sits in tprav_rate_checker.
// Depends on tprav_pkg, tprav_rate_checker and the block itself.
`timescale 1ns / 1ps

module tach_period_to_rate_averager_core_tb;
   import tprav_pkg::*;

   localparam int  HISTORY_DEPTH   = 8;
   localparam int  QUIET_LIMIT     = 2000;
   localparam int  SETTLE_CYCLES   = 40;
   localparam int  PHASE_CAPTURES  = 90;
   localparam logic CSR_INDEX_SPARE = 1'b1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [CAPTURE_W-1:0]  req_capture_time = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [RATE_W-1:0]     rsp_rate_q8;
   logic [RATE_W-1:0]     rsp_average_rate_q8;
   logic                  rsp_zero_period;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatches;
   int outstanding;
   int results_checked;

   logic                 calm = 1'b0;
   int                   pop_hold = 0;
   int                   quiet_cycles = 0;
   int                   captures_sent = 0;
   int                   settings_made = 0;
   logic [CAPTURE_W-1:0] last_sent = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   tach_period_to_rate_averager_core #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_capture_time   (req_capture_time),
      .empty              (empty),
      .pop                (pop),
      .rsp_rate_q8        (rsp_rate_q8),
      .rsp_average_rate_q8(rsp_average_rate_q8),
      .rsp_zero_period    (rsp_zero_period),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   tprav_rate_checker #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .capture_time   (req_capture_time),
      .empty          (empty),
      .pop            (pop),
      .rate_q8        (rsp_rate_q8),
      .average_rate_q8(rsp_average_rate_q8),
      .zero_period    (rsp_zero_period),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .results_checked(results_checked)
   );

   // Result side: pop stalls in random-length bursts, none once calm
   always @(posedge clock) begin
      if (reset) begin
         pop      <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold != 0) begin
         pop_hold <= pop_hold - 1;
         pop      <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         pop_hold <= $urandom_range(0, 10);
         pop      <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Watchdog: end the run when nothing has transferred for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one capture, after an optional gap, and hold it until transferred
   task automatic send_capture(logic [CAPTURE_W-1:0] stamp);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push             <= 1'b1;
      req_capture_time <= stamp;
      do @(posedge clock); while (full);
      last_sent = stamp;
      captures_sent++;
   endtask

   // Hold off until every predicted result has arrived and the block is quiet
   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(logic index, logic is_write, logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (is_write && index == CSR_INDEX_TICK_RATE) settings_made++;
   endtask

   // Change the rate numerator while idle and read it back
   task automatic set_tick_rate(logic [CSR_DATA_W-1:0] value);
      drain();
      csr_access(CSR_INDEX_TICK_RATE, 1'b1, value);
      csr_access(CSR_INDEX_TICK_RATE, 1'b0, '0);
   endtask

   initial begin : stimulus
      logic [CAPTURE_W-1:0] opening_captures [10];
      logic [CSR_DATA_W-1:0] tick_plan [5];
      logic [CAPTURE_W-1:0] stamp;
      int                   pick;

      opening_captures = '{16'h0000, 16'h0001, 16'h0001, 16'hFFFF, 16'h0000,
                           16'h8000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0F0F};
      tick_plan = '{32'd10_000_000, 32'hFFFF_FFFF, 32'd1, 32'd6_400_000, 32'h0};
      tick_plan[4] = $urandom();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset numerator: first capture against zero, repeated stamps, wrap, bit patterns
      foreach (opening_captures[i]) send_capture(opening_captures[i]);

      // Largest numerator: quotients above the output range saturate without the flag;
      // a write to the spare index must leave the numerator alone
      set_tick_rate(32'hFFFF_FFFF);
      csr_access(CSR_INDEX_SPARE, 1'b1, 32'h0000_0005);
      csr_access(CSR_INDEX_TICK_RATE, 1'b0, '0);
      send_capture(last_sent + 16'd1);
      send_capture(last_sent + 16'd255);
      send_capture(last_sent + 16'd256);
      send_capture(last_sent + 16'hFFFF);
      send_capture(last_sent);

      // Zero numerator gives a zero rate
      set_tick_rate(32'h0);
      send_capture(last_sent + 16'd1);
      send_capture(last_sent + 16'h1234);

      // Smallest numerator
      set_tick_rate(32'd1);
      send_capture(last_sent + 16'd1);
      send_capture(last_sent + 16'd2);

      // Random phases: mostly steady tachometer edges, some noise and repeats
      foreach (tick_plan[p]) begin
         set_tick_rate(tick_plan[p]);
         if (p == $size(tick_plan) - 1) calm = 1'b1;
         repeat (PHASE_CAPTURES) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               stamp = last_sent;
            else if (pick < 15)
               stamp = last_sent + CAPTURE_W'($urandom_range(1, 16));
            else if (pick < 25)
               stamp = CAPTURE_W'($urandom());
            else if (pick < 35)
               stamp = last_sent + CAPTURE_W'($urandom_range(16'h8000, 16'hFFFF));
            else
               stamp = last_sent + CAPTURE_W'($urandom_range(100, 20000));
            send_capture(stamp);
         end
      end

      drain();
      $display("Summary: %0d captures over %0d numerator settings, %0d results compared",
               captures_sent, settings_made, results_checked);
      $display("Covered zero periods, saturation, zero numerator, wrap-around and stalls.");
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
